// ===== hdl/rtpss_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the RTP sender statistics scheduler.
// No dependencies.
package rtpss_pkg;

   typedef enum logic [1:0] {
      CMD_RTP_SENT = 2'd0,
      CMD_SR_SENT  = 2'd1,
      CMD_RR_BLOCK = 2'd2,
      CMD_QUERY    = 2'd3
   } cmd_type;

   localparam int unsigned CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_RESUBMIT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REPORT   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FAST     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LOSS_GAP = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW   = 3'd4;

   localparam logic [31:0] RESUBMIT_RST = 32'd1000000000;
   localparam logic [31:0] REPORT_RST   = 32'd1000000000;
   localparam logic [31:0] FAST_RST     = 32'd20000000;
   localparam logic [31:0] LOSS_GAP_RST = 32'd500000000;
   localparam logic [31:0] WINDOW_RST   = 32'd1000000000;

   // One queued request, command decoded to one-hot kind flags, none set for a query
   typedef struct packed {
      logic        is_rtp;
      logic        is_sr;
      logic        is_rr;
      logic [63:0] now_ns;
      logic [15:0] seq_num;
      logic [15:0] packet_length;
      logic [15:0] header_length;
      logic [31:0] last_sr;
      logic [31:0] delay_since_sr;
      logic [31:0] receive_ntp32;
      logic [23:0] cumulative_loss;
      logic [31:0] ext_seq_received;
   } item_type;

   typedef struct packed {
      logic [31:0] resubmit;
      logic [31:0] report;
      logic [31:0] fast;
      logic [31:0] loss_gap;
      logic [31:0] window;
   } cfg_type;

   // Queue handshake between front and back
   typedef struct packed {
      logic valid;
      logic full;
   } q_stat_type;

   typedef struct packed {
      logic [62:0] time_to_report;
      logic [31:0] seq_extended;
      logic [31:0] packets_sent;
      logic [31:0] octets_sent;
      logic [31:0] rtt_ntp;
      logic [31:0] lost_delta;
      logic [31:0] received_delta;
      logic [63:0] report_period;
      logic        window_valid;
      logic [31:0] window_packets;
      logic [31:0] window_octets;
      logic [63:0] window_duration;
   } result_type;

endpackage

// ===== hdl/rtp_sender_stats_scheduler.sv =====
`timescale 1ns / 1ps
// RTP sender statistics scheduler: one result per request, every request
// kind applied by a single combinational state update, so the block sustains
// one request per clock while rsp_ready is held high. A request passes through
// the queue write, then the state update into the output register; the two-entry
// queue lets the input keep accepting while a result waits. Depends on rtpss_pkg,
// rtpss_front and rtpss_back.
module rtp_sender_stats_scheduler #(
   parameter int unsigned EARLY_PACKET_COUNT = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_write_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_cmd,
   input  logic [63:0] req_now_ns,
   input  logic [15:0] req_seq_num,
   input  logic [15:0] req_packet_length,
   input  logic [15:0] req_header_length,
   input  logic [31:0] req_last_sr,
   input  logic [31:0] req_delay_since_sr,
   input  logic [31:0] req_receive_ntp32,
   input  logic [23:0] req_cumulative_loss,
   input  logic [31:0] req_ext_seq_received,
   input  logic [7:0]  req_loss_fraction,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [62:0] rsp_time_to_report,
   output logic [31:0] rsp_seq_extended,
   output logic [31:0] rsp_packets_sent,
   output logic [31:0] rsp_octets_sent,
   output logic [31:0] rsp_rtt_ntp,
   output logic signed [31:0] rsp_lost_delta,
   output logic signed [31:0] rsp_received_delta,
   output logic [63:0] rsp_report_period,
   output logic        rsp_window_valid,
   output logic [31:0] rsp_window_packets,
   output logic [31:0] rsp_window_octets,
   output logic [63:0] rsp_window_duration
);
   rtpss_pkg::cfg_type    cfg_ff, cfg_in;
   rtpss_pkg::item_type   in_item, head;
   rtpss_pkg::q_stat_type stat;
   rtpss_pkg::result_type res;
   rtpss_pkg::cmd_type    cmd;
   logic                  pop;
   logic                  unused_fraction;

   assign unused_fraction = ^req_loss_fraction;

   // write configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            rtpss_pkg::CSR_RESUBMIT: cfg_in.resubmit = csr_write_data;
            rtpss_pkg::CSR_REPORT:   cfg_in.report   = csr_write_data;
            rtpss_pkg::CSR_FAST:     cfg_in.fast     = csr_write_data;
            rtpss_pkg::CSR_LOSS_GAP: cfg_in.loss_gap = csr_write_data;
            rtpss_pkg::CSR_WINDOW:   cfg_in.window   = csr_write_data;
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.resubmit <= rtpss_pkg::RESUBMIT_RST;
         cfg_ff.report   <= rtpss_pkg::REPORT_RST;
         cfg_ff.fast     <= rtpss_pkg::FAST_RST;
         cfg_ff.loss_gap <= rtpss_pkg::LOSS_GAP_RST;
         cfg_ff.window   <= rtpss_pkg::WINDOW_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // classify the request
   always_comb begin
      cmd = rtpss_pkg::cmd_type'(req_cmd);
      in_item = '0;
      in_item.is_rtp = (cmd == rtpss_pkg::CMD_RTP_SENT);
      in_item.is_sr  = (cmd == rtpss_pkg::CMD_SR_SENT);
      in_item.is_rr  = (cmd == rtpss_pkg::CMD_RR_BLOCK);
      in_item.now_ns = req_now_ns;
      in_item.seq_num = req_seq_num;
      in_item.packet_length = req_packet_length;
      in_item.header_length = req_header_length;
      in_item.last_sr = req_last_sr;
      in_item.delay_since_sr = req_delay_since_sr;
      in_item.receive_ntp32 = req_receive_ntp32;
      in_item.cumulative_loss = req_cumulative_loss;
      in_item.ext_seq_received = req_ext_seq_received;
   end

   rtpss_front u_front (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .in_item(in_item), .pop(pop), .head(head), .stat(stat)
   );

   rtpss_back #(.EARLY_PACKET_COUNT(EARLY_PACKET_COUNT)) u_back (
      .clock(clock), .reset(reset), .cfg(cfg_ff), .item(head), .stat(stat),
      .pop(pop), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(res)
   );

   assign rsp_time_to_report  = res.time_to_report;
   assign rsp_seq_extended    = res.seq_extended;
   assign rsp_packets_sent    = res.packets_sent;
   assign rsp_octets_sent     = res.octets_sent;
   assign rsp_rtt_ntp         = res.rtt_ntp;
   assign rsp_lost_delta      = res.lost_delta;
   assign rsp_received_delta  = res.received_delta;
   assign rsp_report_period   = res.report_period;
   assign rsp_window_valid    = res.window_valid;
   assign rsp_window_packets  = res.window_packets;
   assign rsp_window_octets   = res.window_octets;
   assign rsp_window_duration = res.window_duration;

   // full queue must refuse requests
   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      stat.full |-> !req_ready) else $error("request accepted into full queue");

   // a pop needs a queued request
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      pop |-> stat.valid) else $error("pop from empty queue");

   // an open window reports no counts
   a_window_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_window_valid) |-> (rsp_window_packets == 32'd0
         && rsp_window_duration == 64'd0)) else $error("window fields without close");
endmodule

// ===== hdl/rtpss_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts requests, already decoded by the top level, and holds them
// in a two-entry queue. Depends on rtpss_pkg.
module rtpss_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  rtpss_pkg::item_type  in_item,
   input  logic                 pop,
   output rtpss_pkg::item_type  head,
   output rtpss_pkg::q_stat_type stat
);
   rtpss_pkg::item_type q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       push;

   assign req_ready = (fill_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign head      = q_ff[rd_ptr_ff];
   assign stat.valid = (fill_ff != 2'd0);
   assign stat.full  = (fill_ff == 2'd2);

   // advance pointers and fill count
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // hold payload
   always_ff @(posedge clock) begin
      if (push) q_ff[wr_ptr_ff] <= in_item;
   end
endmodule

// ===== hdl/rtpss_back.sv =====
`timescale 1ns / 1ps
// Back end: applies one queued request per cycle, while the result register is
// free or being taken, to the stream state and registers the result. Depends on rtpss_pkg.
module rtpss_back #(
   parameter int unsigned EARLY_PACKET_COUNT = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  rtpss_pkg::cfg_type    cfg,
   input  rtpss_pkg::item_type   item,
   input  rtpss_pkg::q_stat_type stat,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rtpss_pkg::result_type rsp
);
   localparam logic [31:0] EarlyCount = 32'(EARLY_PACKET_COUNT);

   logic [31:0] pay_ff, pay_in, hdr_ff, hdr_in, rtcp_ff, rtcp_in;
   logic [31:0] pc_ff, pc_in, ext_ff, ext_in;
   logic [63:0] snap_t_ff, snap_t_in;
   logic [31:0] s_pay_ff, s_pay_in, s_hdr_ff, s_hdr_in, s_rtcp_ff, s_rtcp_in;
   logic [31:0] s_pc_ff, s_pc_in;
   logic [31:0] r_seq_ff, r_seq_in;
   logic [63:0] r_time_ff, r_time_in;
   logic [23:0] r_loss_ff, r_loss_in;
   logic [63:0] sr_t_ff, sr_t_in, sched_ff, sched_in;
   logic [31:0] lsr_loss_ff, lsr_loss_in, rtt_ff, rtt_in;
   logic        out_v_ff, out_v_in;
   rtpss_pkg::result_type res_ff, res_in;

   logic        seed;
   logic [31:0] ext_base;
   logic [15:0] step;
   logic [63:0] snap_base, wdiff, ahead, srdiff, dsched;
   logic        wclose;
   logic [31:0] lost_d;

   assign pop       = stat.valid && (!out_v_ff || rsp_ready);
   assign rsp_valid = out_v_ff;
   assign rsp       = res_ff;

   // apply the head request to the state
   always_comb begin
      pay_in = pay_ff; hdr_in = hdr_ff; rtcp_in = rtcp_ff; pc_in = pc_ff; ext_in = ext_ff;
      snap_t_in = snap_t_ff; s_pay_in = s_pay_ff; s_hdr_in = s_hdr_ff;
      s_rtcp_in = s_rtcp_ff; s_pc_in = s_pc_ff;
      r_seq_in = r_seq_ff; r_time_in = r_time_ff; r_loss_in = r_loss_ff;
      sr_t_in = sr_t_ff; sched_in = sched_ff; lsr_loss_in = lsr_loss_ff; rtt_in = rtt_ff;
      res_in = '0;

      seed      = (pay_ff == 32'd0);
      ext_base  = seed ? ({16'd0, item.seq_num} - 32'd1) : ext_ff;
      step      = item.seq_num - ext_base[15:0];
      snap_base = seed ? item.now_ns : snap_t_ff;
      wdiff     = item.now_ns - snap_base;
      wclose    = !wdiff[63] && (wdiff >= {32'd0, cfg.window});
      ahead     = sched_ff - item.now_ns;
      lost_d    = {8'd0, item.cumulative_loss} - {8'd0, r_loss_ff};

      if (item.is_rtp) begin
         if (seed) begin
            snap_t_in = item.now_ns;
            r_seq_in  = ext_base;
            r_time_in = item.now_ns;
         end
         pay_in = pay_ff + ({16'd0, item.packet_length} - {16'd0, item.header_length});
         hdr_in = hdr_ff + {16'd0, item.header_length};
         pc_in  = pc_ff + 32'd1;
         ext_in = (step != 16'd0 && !step[15]) ? ext_base + {16'd0, step} : ext_base;
         if (wclose) begin
            res_in.window_valid    = 1'b1;
            res_in.window_packets  = pc_in - s_pc_ff;
            res_in.window_octets   = (pay_in - s_pay_ff) + (hdr_in - s_hdr_ff)
                                     + (rtcp_ff - s_rtcp_ff);
            res_in.window_duration = wdiff;
            s_pay_in  = pay_in;
            s_hdr_in  = hdr_in;
            s_rtcp_in = rtcp_ff;
            s_pc_in   = pc_in;
            snap_t_in = item.now_ns;
         end
      end else if (item.is_sr) begin
         sr_t_in     = item.now_ns;
         sched_in    = item.now_ns + {32'd0, cfg.resubmit};
         lsr_loss_in = 32'd0;
         rtcp_in     = rtcp_ff + {16'd0, item.packet_length};
      end else if (item.is_rr) begin
         if (item.last_sr != 32'd0 && item.delay_since_sr != 32'd0) begin
            rtt_in = item.receive_ntp32 - item.last_sr - item.delay_since_sr;
            if (!ahead[63] && ahead > {32'd0, cfg.report})
               sched_in = item.now_ns + {32'd0, cfg.report};
         end else begin
            sched_in = item.now_ns + {32'd0, cfg.fast};
            rtt_in   = 32'd0;
         end
         res_in.lost_delta     = lost_d;
         res_in.received_delta = item.ext_seq_received - r_seq_ff;
         res_in.report_period  = item.now_ns - r_time_ff;
         lsr_loss_in = lsr_loss_ff + lost_d;
         r_loss_in   = item.cumulative_loss;
         r_seq_in    = item.ext_seq_received;
         r_time_in   = item.now_ns;
      end

      // time to next sender report from the updated state
      srdiff = item.now_ns - sr_t_in;
      dsched = sched_in - item.now_ns;
      if (sched_in == 64'd0)
         res_in.time_to_report = (pc_in > EarlyCount) ? 63'd0 : {31'd0, cfg.resubmit};
      else if (lsr_loss_in != 32'd0 && !lsr_loss_in[31] && !srdiff[63]
               && srdiff >= {32'd0, cfg.loss_gap})
         res_in.time_to_report = 63'd0;
      else
         res_in.time_to_report = dsched[63] ? 63'd0 : dsched[62:0];

      res_in.seq_extended = ext_in;
      res_in.packets_sent = pc_in;
      res_in.octets_sent  = pay_in + hdr_in;
      res_in.rtt_ntp      = rtt_in;

      out_v_in = pop ? 1'b1 : (rsp_ready ? 1'b0 : out_v_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pay_ff <= '0; hdr_ff <= '0; rtcp_ff <= '0; pc_ff <= '0; ext_ff <= '0;
         snap_t_ff <= '0; s_pay_ff <= '0; s_hdr_ff <= '0; s_rtcp_ff <= '0; s_pc_ff <= '0;
         r_seq_ff <= '0; r_time_ff <= '0; r_loss_ff <= '0;
         sr_t_ff <= '0; sched_ff <= '0; lsr_loss_ff <= '0; rtt_ff <= '0;
         out_v_ff <= 1'b0;
      end else begin
         out_v_ff <= out_v_in;
         if (pop) begin
            pay_ff <= pay_in; hdr_ff <= hdr_in; rtcp_ff <= rtcp_in; pc_ff <= pc_in;
            ext_ff <= ext_in; snap_t_ff <= snap_t_in; s_pay_ff <= s_pay_in;
            s_hdr_ff <= s_hdr_in; s_rtcp_ff <= s_rtcp_in; s_pc_ff <= s_pc_in;
            r_seq_ff <= r_seq_in; r_time_ff <= r_time_in; r_loss_ff <= r_loss_in;
            sr_t_ff <= sr_t_in; sched_ff <= sched_in; lsr_loss_ff <= lsr_loss_in;
            rtt_ff <= rtt_in;
         end
      end
   end

   // hold result until taken
   always_ff @(posedge clock) begin
      if (pop) res_ff <= res_in;
   end
endmodule
